/* design/dlhc_pkg.sv */
// Shared types and constants for the dual level hysteresis classifier.
package dlhc_pkg;

  // Field widths
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned THR_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Fault limits, in hundredths
  localparam logic [THR_W-1:0] VOLT_FAULT_LIMIT = 20'd365;
  localparam logic [THR_W-1:0] CURR_FAULT_LIMIT = 20'd10000;

  // Channel levels
  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_REDUCE = 2'd1,
    LVL_STOP   = 2'd2,
    LVL_FAULT  = 2'd3
  } level_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLT_RISE_HIGH = 3'd0,
    REG_VOLT_FALL_MID  = 3'd1,
    REG_VOLT_RISE_MID  = 3'd2,
    REG_VOLT_FALL_LOW  = 3'd3,
    REG_CURR_RISE_HIGH = 3'd4,
    REG_CURR_FALL_MID  = 3'd5,
    REG_CURR_RISE_MID  = 3'd6,
    REG_CURR_FALL_LOW  = 3'd7
  } cfg_reg_t;

  // One channel's hysteresis thresholds, in hundredths
  typedef struct packed {
    logic [THR_W-1:0] rise_high;
    logic [THR_W-1:0] fall_mid;
    logic [THR_W-1:0] rise_mid;
    logic [THR_W-1:0] fall_low;
  } thr_t;

  localparam thr_t VOLT_THR_RESET = '{
    rise_high: 20'd355, fall_mid: 20'd350, rise_mid: 20'd350, fall_low: 20'd345
  };
  localparam thr_t CURR_THR_RESET = '{
    rise_high: 20'd8000, fall_mid: 20'd8000, rise_mid: 20'd7500, fall_low: 20'd7500
  };

endpackage

/* design/dual_level_hysteresis_classifier_unit.sv */
// Top level of the dual level hysteresis classifier.
// Each input beat (a 16-bit voltage and current reading in tenths) is
// registered in the input register, then classified against the level and
// threshold registers, and the result lands in the output register. One beat
// is accepted every cycle as long as the output side keeps up, the update of
// the two 2-bit level registers setting that rate. Voltage or current above
// its fault limit latches that channel at level 3 until reset, and a voltage
// fault leaves the current level untouched for that beat. The user must write
// thresholds through cfg_write_en/cfg_index/cfg_data only while the block is
// idle; the block itself does not enforce it.
module dual_level_hysteresis_classifier_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write_en,
  input  logic [dlhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlhc_pkg::THR_W-1:0]      cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dlhc_pkg::RAW_W-1:0]      voltage_raw,
  input  logic [dlhc_pkg::RAW_W-1:0]      current_raw,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      voltage_level,
  output logic [1:0]                      current_level,
  output logic                            reading_ok
);

  dlhc_pkg::thr_t              volt_thr;
  dlhc_pkg::thr_t              curr_thr;
  logic                        s1_valid;
  logic [dlhc_pkg::RAW_W-1:0]  s1_volt;
  logic [dlhc_pkg::RAW_W-1:0]  s1_curr;
  logic                        s1_adv;
  logic                        in_take;
  dlhc_pkg::level_t            v_level;
  dlhc_pkg::level_t            v_next;
  dlhc_pkg::level_t            c_level;
  dlhc_pkg::level_t            c_next;
  logic                        v_fault;
  logic                        c_fault;

  dlhc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .volt_thr     (volt_thr),
    .curr_thr     (curr_thr)
  );

  // Flow control: stage 1 moves on when the output register is free or drains
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_volt <= voltage_raw;
      s1_curr <= current_raw;
    end
  end

  dlhc_chan u_volt (
    .clk         (clk),
    .rst         (rst),
    .raw         (s1_volt),
    .thr         (volt_thr),
    .fault_limit (dlhc_pkg::VOLT_FAULT_LIMIT),
    .en          (1'b1),
    .update      (s1_valid && s1_adv),
    .level       (v_level),
    .level_next  (v_next),
    .fault       (v_fault)
  );

  // Current channel is skipped on a voltage fault
  dlhc_chan u_curr (
    .clk         (clk),
    .rst         (rst),
    .raw         (s1_curr),
    .thr         (curr_thr),
    .fault_limit (dlhc_pkg::CURR_FAULT_LIMIT),
    .en          (!v_fault),
    .update      (s1_valid && s1_adv),
    .level       (c_level),
    .level_next  (c_next),
    .fault       (c_fault)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      voltage_level <= v_next;
      current_level <= c_next;
      reading_ok    <= !(v_fault || (!v_fault && c_fault));
    end
  end

  // Fault level never clears
  a_volt_latch: assert property (@(posedge clk) disable iff (rst)
    (v_level == dlhc_pkg::LVL_FAULT) |=> (v_level == dlhc_pkg::LVL_FAULT))
    else $error("voltage fault level left");

  a_curr_latch: assert property (@(posedge clk) disable iff (rst)
    (c_level == dlhc_pkg::LVL_FAULT) |=> (c_level == dlhc_pkg::LVL_FAULT))
    else $error("current fault level left");

  // A failed reading always shows a faulted channel
  a_fail_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reading_ok) |->
      (voltage_level == dlhc_pkg::LVL_FAULT || current_level == dlhc_pkg::LVL_FAULT))
    else $error("reading_ok low without fault level");

  // A voltage fault leaves the current level alone
  a_skip_curr: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && v_fault) |=> $stable(c_level))
    else $error("current level changed on voltage fault");

endmodule

/* design/dlhc_cfg.sv */
// Threshold register file for both channels.
module dlhc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [dlhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlhc_pkg::THR_W-1:0]      cfg_data,
  output dlhc_pkg::thr_t                  volt_thr,
  output dlhc_pkg::thr_t                  curr_thr
);

  // Register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_thr <= dlhc_pkg::VOLT_THR_RESET;
      curr_thr <= dlhc_pkg::CURR_THR_RESET;
    end else if (cfg_write_en) begin
      unique case (dlhc_pkg::cfg_reg_t'(cfg_index))
        dlhc_pkg::REG_VOLT_RISE_HIGH: volt_thr.rise_high <= cfg_data;
        dlhc_pkg::REG_VOLT_FALL_MID:  volt_thr.fall_mid  <= cfg_data;
        dlhc_pkg::REG_VOLT_RISE_MID:  volt_thr.rise_mid  <= cfg_data;
        dlhc_pkg::REG_VOLT_FALL_LOW:  volt_thr.fall_low  <= cfg_data;
        dlhc_pkg::REG_CURR_RISE_HIGH: curr_thr.rise_high <= cfg_data;
        dlhc_pkg::REG_CURR_FALL_MID:  curr_thr.fall_mid  <= cfg_data;
        dlhc_pkg::REG_CURR_RISE_MID:  curr_thr.rise_mid  <= cfg_data;
        dlhc_pkg::REG_CURR_FALL_LOW:  curr_thr.fall_low  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/dlhc_chan.sv */
// One channel: scaling, fault check, hysteresis update and level register.
module dlhc_chan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dlhc_pkg::RAW_W-1:0]  raw,
  input  dlhc_pkg::thr_t              thr,
  input  logic [dlhc_pkg::THR_W-1:0]  fault_limit,
  input  logic                        en,         // channel takes part in this beat
  input  logic                        update,     // commit level_next
  output dlhc_pkg::level_t            level,
  output dlhc_pkg::level_t            level_next,
  output logic                        fault
);

  logic [dlhc_pkg::THR_W-1:0] x10;
  dlhc_pkg::level_t           hyst;

  // raw * 10 as two shifts; fits in 20 bits
  assign x10 = ({4'd0, raw} << 3) + ({4'd0, raw} << 1);
  assign fault = (x10 > fault_limit);

  // Hysteresis transitions, first match wins; fault level is sticky
  always_comb begin
    hyst = level;
    case (level)
      dlhc_pkg::LVL_STOP: begin
        if (x10 < thr.fall_low)      hyst = dlhc_pkg::LVL_NORMAL;
        else if (x10 < thr.fall_mid) hyst = dlhc_pkg::LVL_REDUCE;
      end
      dlhc_pkg::LVL_REDUCE: begin
        if (x10 > thr.rise_high)     hyst = dlhc_pkg::LVL_STOP;
        else if (x10 < thr.fall_low) hyst = dlhc_pkg::LVL_NORMAL;
      end
      dlhc_pkg::LVL_NORMAL: begin
        if (x10 > thr.rise_high)     hyst = dlhc_pkg::LVL_STOP;
        else if (x10 > thr.rise_mid) hyst = dlhc_pkg::LVL_REDUCE;
      end
      default: hyst = level;
    endcase
  end

  always_comb begin
    if (!en)        level_next = level;
    else if (fault) level_next = dlhc_pkg::LVL_FAULT;
    else            level_next = hyst;
  end

  // Level register
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= dlhc_pkg::LVL_NORMAL;
    end else if (update) begin
      level <= level_next;
    end
  end

endmodule

/* test/dlhc_checker.sv */
// Checker for the dual level hysteresis classifier: predicts each reading's class and compares.
module dlhc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [dlhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlhc_pkg::THR_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [dlhc_pkg::RAW_W-1:0]      voltage_raw,
  input  logic [dlhc_pkg::RAW_W-1:0]      current_raw,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      voltage_level,
  input  logic [1:0]                      current_level,
  input  logic                            reading_ok,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlhc_pkg::*;

  typedef struct packed {
    level_t volt;
    level_t curr;
    logic   ok;
  } reading_class_t;

  // Shadow copy of the block's thresholds and levels
  thr_t           volt_thr = VOLT_THR_RESET;
  thr_t           curr_thr = CURR_THR_RESET;
  level_t         volt_lvl = LVL_NORMAL;
  level_t         curr_lvl = LVL_NORMAL;
  reading_class_t expected_classes[$];
  int             mismatches = 0;

  // Hysteresis move among normal, reduce and stop; fault is sticky
  function automatic level_t hysteresis_step(level_t lvl, logic [THR_W-1:0] x, thr_t t);
    level_t nxt;
    nxt = lvl;
    case (lvl)
      LVL_STOP: begin
        if (x < t.fall_low) nxt = LVL_NORMAL;
        else if (x < t.fall_mid) nxt = LVL_REDUCE;
      end
      LVL_REDUCE: begin
        if (x > t.rise_high) nxt = LVL_STOP;
        else if (x < t.fall_low) nxt = LVL_NORMAL;
      end
      LVL_NORMAL: begin
        if (x > t.rise_high) nxt = LVL_STOP;
        else if (x > t.rise_mid) nxt = LVL_REDUCE;
      end
      default: nxt = lvl;
    endcase
    return nxt;
  endfunction

  // Update both channels for one reading and return the class it reports
  function automatic reading_class_t classify_reading(logic [RAW_W-1:0] v, logic [RAW_W-1:0] c);
    logic [THR_W-1:0] v_hund;
    logic [THR_W-1:0] c_hund;
    reading_class_t   res;
    v_hund = THR_W'(v);
    v_hund = THR_W'(v_hund * 10);
    c_hund = THR_W'(c);
    c_hund = THR_W'(c_hund * 10);
    res.ok = 1'b1;
    if (v_hund > VOLT_FAULT_LIMIT) begin
      // voltage fault: current channel is left alone
      volt_lvl = LVL_FAULT;
      res.ok   = 1'b0;
    end else begin
      volt_lvl = hysteresis_step(volt_lvl, v_hund, volt_thr);
      if (c_hund > CURR_FAULT_LIMIT) begin
        curr_lvl = LVL_FAULT;
        res.ok   = 1'b0;
      end else begin
        curr_lvl = hysteresis_step(curr_lvl, c_hund, curr_thr);
      end
    end
    res.volt = volt_lvl;
    res.curr = curr_lvl;
    return res;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin
    reading_class_t want;
    if (rst) begin
      volt_thr = VOLT_THR_RESET;
      curr_thr = CURR_THR_RESET;
      volt_lvl = LVL_NORMAL;
      curr_lvl = LVL_NORMAL;
      expected_classes.delete();
    end else begin
      // results first: nothing accepted at this edge can come out at it
      if (out_valid && !out_stall) begin
        if (expected_classes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected beat v=%0d c=%0d ok=%0d", $realtime,
                     voltage_level, current_level, reading_ok);
        end else begin
          want = expected_classes.pop_front();
          if (want.volt !== voltage_level || want.curr !== current_level ||
              want.ok !== reading_ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected v=%0d c=%0d ok=%0d, got v=%0d c=%0d ok=%0d",
                       $realtime, want.volt, want.curr, want.ok,
                       voltage_level, current_level, reading_ok);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_classes.push_back(classify_reading(voltage_raw, current_raw));
      if (cfg_write_en) begin
        case (cfg_index)
          REG_VOLT_RISE_HIGH: volt_thr.rise_high = cfg_data;
          REG_VOLT_FALL_MID:  volt_thr.fall_mid  = cfg_data;
          REG_VOLT_RISE_MID:  volt_thr.rise_mid  = cfg_data;
          REG_VOLT_FALL_LOW:  volt_thr.fall_low  = cfg_data;
          REG_CURR_RISE_HIGH: curr_thr.rise_high = cfg_data;
          REG_CURR_FALL_MID:  curr_thr.fall_mid  = cfg_data;
          REG_CURR_RISE_MID:  curr_thr.rise_mid  = cfg_data;
          REG_CURR_FALL_LOW:  curr_thr.fall_low  = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_classes.size();
    errors  <= mismatches;
  end

endmodule

/* test/dual_level_hysteresis_classifier_unit_tb.sv */
// Testbench top for the dual level hysteresis classifier: stimulus, flow control and verdict.
module dual_level_hysteresis_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dlhc_pkg::*;

  localparam int PHASE_READINGS = 210;
  localparam int HOLD_CYCLES    = 80;
  localparam int VOLT_SAFE_MAX  = 36;    // highest raw voltage below the fault limit
  localparam int CURR_SAFE_MAX  = 1000;  // highest raw current not above the fault limit

  // Kinds of threshold sets
  localparam int THR_RANDOM   = 0;
  localparam int THR_ZERO     = 1;
  localparam int THR_ONES     = 2;
  localparam int THR_ORDERED  = 3;
  localparam int THR_INVERTED = 4;
  localparam int THR_DEFAULT  = 5;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_data     = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [RAW_W-1:0] voltage_raw  = '0;
  logic [RAW_W-1:0] current_raw  = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [1:0]       voltage_level;
  logic [1:0]       current_level;
  logic             reading_ok;
  int               fail_count;
  int               pending_count;

  // Flow control knobs, written by the stimulus process only
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_req  = 1'b0;
  // Receiver-side hold bookkeeping
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // Thresholds last written, used to aim readings near them
  thr_t volt_set = VOLT_THR_RESET;
  thr_t curr_set = CURR_THR_RESET;

  dual_level_hysteresis_classifier_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .voltage_raw(voltage_raw), .current_raw(current_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .voltage_level(voltage_level), .current_level(current_level), .reading_ok(reading_ok)
  );

  dlhc_checker level_check (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .voltage_raw(voltage_raw), .current_raw(current_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .voltage_level(voltage_level), .current_level(current_level), .reading_ok(reading_ok),
    .errors(fail_count), .pending(pending_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Output side: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= recv_gaps && ($urandom_range(0, 99) < 33);
      end
    end
  end

  // Offer one reading, with random idle cycles ahead of it
  task automatic send_reading(input logic [RAW_W-1:0] v, input logic [RAW_W-1:0] c);
    while (send_gaps && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    voltage_raw <= v;
    current_raw <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every reading has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [THR_W-1:0] d);
    cfg_write_en <= 1'b1;
    cfg_index    <= r;
    cfg_data     <= d;
    @(posedge clk);
  endtask

  // Write all eight thresholds, block idle
  task automatic load_thresholds(input thr_t v, input thr_t c);
    write_reg(REG_VOLT_RISE_HIGH, v.rise_high);
    write_reg(REG_VOLT_FALL_MID,  v.fall_mid);
    write_reg(REG_VOLT_RISE_MID,  v.rise_mid);
    write_reg(REG_VOLT_FALL_LOW,  v.fall_low);
    write_reg(REG_CURR_RISE_HIGH, c.rise_high);
    write_reg(REG_CURR_FALL_MID,  c.fall_mid);
    write_reg(REG_CURR_RISE_MID,  c.rise_mid);
    write_reg(REG_CURR_FALL_LOW,  c.fall_low);
    cfg_write_en <= 1'b0;
    volt_set = v;
    curr_set = c;
  endtask

  function automatic int rand_thr(input int ceiling);
    if ($urandom_range(0, 1) == 0) return 10 * $urandom_range(0, ceiling / 10);
    return $urandom_range(0, ceiling);
  endfunction

  // One channel's threshold set; ceiling is a bit above the fault limit
  function automatic thr_t make_thresholds(input int kind, input int ceiling, input thr_t dflt);
    thr_t t;
    int   b;
    b = 10 * $urandom_range(2, ceiling / 10 - 4);
    case (kind)
      THR_RANDOM: begin
        t.rise_high = THR_W'(rand_thr(ceiling));
        t.fall_mid  = THR_W'(rand_thr(ceiling));
        t.rise_mid  = THR_W'(rand_thr(ceiling));
        t.fall_low  = THR_W'(rand_thr(ceiling));
      end
      THR_ZERO: t = '0;
      THR_ONES: t = '1;
      THR_ORDERED: begin
        t.rise_mid  = THR_W'(b);
        t.rise_high = THR_W'(b + $urandom_range(0, 30));
        t.fall_mid  = THR_W'(b + $urandom_range(0, 10));
        t.fall_low  = THR_W'(b - $urandom_range(0, 20));
      end
      THR_INVERTED: begin
        t.rise_high = THR_W'(b);
        t.rise_mid  = THR_W'(b + $urandom_range(0, 30));
        t.fall_low  = THR_W'(b + $urandom_range(0, 30));
        t.fall_mid  = THR_W'(b / 2);
      end
      default: t = dflt;
    endcase
    return t;
  endfunction

  // Raw reading near one of the thresholds, or anywhere in the safe range
  function automatic logic [RAW_W-1:0] pick_raw(input thr_t t, input int ceiling);
    logic [THR_W-1:0] thr;
    int               raw;
    case ($urandom_range(0, 3))
      0: thr = t.rise_high;
      1: thr = t.fall_mid;
      2: thr = t.rise_mid;
      default: thr = t.fall_low;
    endcase
    raw = int'(thr / 10) + int'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 2) == 0) raw = $urandom_range(0, ceiling);
    if (raw < 0) raw = 0;
    if (raw > ceiling) raw = ceiling;
    return raw[RAW_W-1:0];
  endfunction

  // Hard stop
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin
    int kinds[7];
    logic [RAW_W-1:0] v;
    logic [RAW_W-1:0] c;
    kinds = '{THR_DEFAULT, THR_RANDOM, THR_ZERO, THR_ORDERED, THR_ONES, THR_INVERTED,
              THR_RANDOM};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk both channels through their moves at the reset thresholds
    send_reading(16'd0,  16'd0);
    send_reading(16'd35, 16'd750);   // exactly on rise thresholds: no move
    send_reading(16'd36, 16'd751);   // voltage to stop, current to reduce
    send_reading(16'd35, 16'd800);   // exactly on fall thresholds: hold
    send_reading(16'd34, 16'd801);   // voltage to normal, current to stop
    send_reading(16'd36, 16'd799);   // current stop to reduce
    send_reading(16'd35, 16'd749);   // current reduce to normal
    send_reading(16'd36, 16'd1000);  // current exactly at fault limit
    send_reading(16'd34, 16'd700);   // both stop to normal
    send_reading(16'd36, 16'd1000);
    send_reading(16'd36, 16'd760);
    drain();

    // Threshold sets with well-formed readings not above the fault limits
    foreach (kinds[p]) begin
      send_gaps = (p != 2);
      recv_gaps = (p != 2);
      load_thresholds(make_thresholds(kinds[p], 400, VOLT_THR_RESET),
                      make_thresholds(kinds[p], 10100, CURR_THR_RESET));
      for (int i = 0; i < PHASE_READINGS; i++) begin
        if (i == 100 && (p == 1 || p == 4)) hold_req = ~hold_req;
        send_reading(pick_raw(volt_set, VOLT_SAFE_MAX), pick_raw(curr_set, CURR_SAFE_MAX));
      end
      drain();
    end

    // Fault latching, then the full input range
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    load_thresholds(VOLT_THR_RESET, CURR_THR_RESET);
    send_reading(16'd0,  16'd801);   // current to stop
    send_reading(16'd37, 16'd0);     // voltage fault: current stays at stop
    send_reading(16'd0,  16'd0);     // voltage latched, current still moves
    send_reading(16'd0,  16'd1001);  // current fault
    send_reading(16'd0,  16'd0);     // both latched, reading ok again
    send_reading(16'hFFFF, 16'hFFFF);
    send_reading(16'hFFFF, 16'd0);
    send_reading(16'd0,  16'hFFFF);
    for (int i = 0; i < 150; i++) begin
      v = RAW_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 40));
      c = RAW_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 1100));
      send_reading(v, c);
    end
    drain();
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/dlhc_pkg.sv
design/dlhc_cfg.sv
design/dlhc_chan.sv
design/dual_level_hysteresis_classifier_unit.sv
test/dlhc_checker.sv
test/dual_level_hysteresis_classifier_unit_tb.sv
